### rtl/core/spk_pkg.sv
// Shared types, constants and word functions for the Speck128/128 encrypt block.
// No dependencies; imported by spk_round_cell, speck_block_encrypt and the testbench.
`timescale 1ns / 1ps

package spk_pkg;

  // Cipher geometry
  localparam int ROUND_COUNT = 32;
  localparam int ROUND_W     = $clog2(ROUND_COUNT);
  localparam int WORD_W      = 64;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_A = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_B = 1'd1;

  // Word state carried from cell to cell: data pair and key schedule pair
  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] rk;
  } spk_lane_t;

  function automatic logic [WORD_W-1:0] rotr8(input logic [WORD_W-1:0] v);
    return {v[7:0], v[WORD_W-1:8]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl3(input logic [WORD_W-1:0] v);
    return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
  endfunction

endpackage

### rtl/core/speck_block_encrypt.sv
// Top level of the Speck128/128 block encryptor: key registers and a chain of round cells.
// Depends on spk_pkg and spk_round_cell.
//
// Usage:
//   Key words are written through cfg_write/cfg_index/cfg_data (index 0 key_word_a,
//   index 1 key_word_b) while no request is in flight; both reset to zero.
//   Input requests (block_x, block_y) are taken when in_valid is high and in_stall low.
//   Results (cipher_x, cipher_y) are offered with out_valid and taken when out_stall
//   is low.
// Path: an accepted request passes through the chain of registered round cells, one per
//   round; the last cell's register is the output register.
// Throughput: one block per cycle while the output is not stalled, since every round has its own cell.
// Stall: the whole chain holds while a result waits under out_stall; in_stall is
//   then raised and nothing in the chain changes. Empty slots in the chain still advance
//   whenever the output is free.
// Reset: clears the key registers and all cell valid flags; out_valid goes low.
`timescale 1ns / 1ps

module speck_block_encrypt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [spk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spk_pkg::WORD_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spk_pkg::WORD_W-1:0]      block_x,
  input  logic [spk_pkg::WORD_W-1:0]      block_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spk_pkg::WORD_W-1:0]      cipher_x,
  output logic [spk_pkg::WORD_W-1:0]      cipher_y
);
  import spk_pkg::*;

  logic [WORD_W-1:0] key_word_a;
  logic [WORD_W-1:0] key_word_b;
  logic              advance;
  spk_lane_t         entry_lane;
  logic      [ROUND_COUNT-1:0] cell_valid;
  spk_lane_t [ROUND_COUNT-1:0] cell_lane;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_a <= '0;
      key_word_b <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_WORD_A: key_word_a <= cfg_data;
        REG_KEY_WORD_B: key_word_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain moves unless a result is waiting under stall
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Round 0 input: plaintext and raw key words
  always_comb begin
    entry_lane.x   = block_x;
    entry_lane.y   = block_y;
    entry_lane.mix = key_word_a;
    entry_lane.rk  = key_word_b;
  end

  // Round cells
  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    if (i == 0) begin : g_first
      spk_round_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .advance    (advance),
        .round_idx  (ROUND_W'(i)),
        .prev_valid (in_valid),
        .prev_lane  (entry_lane),
        .valid      (cell_valid[i]),
        .lane       (cell_lane[i])
      );
    end else begin : g_rest
      spk_round_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .advance    (advance),
        .round_idx  (ROUND_W'(i)),
        .prev_valid (cell_valid[i-1]),
        .prev_lane  (cell_lane[i-1]),
        .valid      (cell_valid[i]),
        .lane       (cell_lane[i])
      );
    end
  end

  // Result from the last cell
  assign out_valid = cell_valid[ROUND_COUNT-1];
  assign cipher_x  = cell_lane[ROUND_COUNT-1].x;
  assign cipher_y  = cell_lane[ROUND_COUNT-1].y;

  // Checks
  a_reset_clears : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");
  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(cell_valid))
    else $error("chain moved while stalled");
  a_bubble_enters : assert property (@(posedge clk) disable iff (rst)
    (advance && !in_valid) |=> !cell_valid[0])
    else $error("item invented at chain entry");
  a_item_enters : assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid) |=> cell_valid[0])
    else $error("accepted request lost at chain entry");
  a_shift_last : assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_valid == $past(cell_valid[ROUND_COUNT-2])))
    else $error("output flag does not follow the chain");

endmodule

### rtl/core/spk_round_cell.sv
// One Speck round cell: a data round plus one key schedule step, registered.
// Depends on spk_pkg for the lane type and rotate functions.
`timescale 1ns / 1ps

module spk_round_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [spk_pkg::ROUND_W-1:0] round_idx,
  input  logic                       prev_valid,
  input  spk_pkg::spk_lane_t         prev_lane,
  output logic                       valid,
  output spk_pkg::spk_lane_t         lane
);
  import spk_pkg::*;

  spk_lane_t lane_next;
  logic [WORD_W-1:0] x_sum;
  logic [WORD_W-1:0] mix_sum;

  // Data round keyed by the incoming round key; schedule step with this round's index
  always_comb begin
    x_sum         = rotr8(prev_lane.x) + prev_lane.y;
    lane_next.x   = x_sum ^ prev_lane.rk;
    lane_next.y   = rotl3(prev_lane.y) ^ lane_next.x;
    mix_sum       = rotr8(prev_lane.mix) + prev_lane.rk;
    lane_next.mix = mix_sum ^ {{(WORD_W-ROUND_W){1'b0}}, round_idx};
    lane_next.rk  = rotl3(prev_lane.rk) ^ lane_next.mix;
  end

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      lane <= lane_next;
    end
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for speck_block_encrypt (Speck128/128, one block per request).
// Uses spk_pkg for widths, round count and key register indexes; needs only the RTL.
`timescale 1ns / 1ps

module testbench;

  import spk_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } word_pair_t;

  localparam logic [WORD_W-1:0] ALL_ONES  = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] ALT_A     = {(WORD_W/2){2'b10}};
  localparam logic [WORD_W-1:0] ALT_5     = {(WORD_W/2){2'b01}};
  localparam logic [WORD_W-1:0] TOP_BIT   = {1'b1, {(WORD_W-1){1'b0}}};
  // Published Speck128/128 key and plaintext words
  localparam logic [WORD_W-1:0] VEC_KEY_A = 64'h0f0e0d0c0b0a0908;
  localparam logic [WORD_W-1:0] VEC_KEY_B = 64'h0706050403020100;
  localparam logic [WORD_W-1:0] VEC_PT_X  = 64'h6c61766975716520;
  localparam logic [WORD_W-1:0] VEC_PT_Y  = 64'h7469206564616d20;
  localparam int DRAIN_CYCLES = ROUND_COUNT + 8;
  localparam int HOLD_CYCLES  = 150;
  // Early in a random phase, so plenty of requests are still queued during the hold
  localparam int HOLD_AFTER   = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [WORD_W-1:0] block_x = '0;
  logic [WORD_W-1:0] block_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [WORD_W-1:0] cipher_x;
  logic [WORD_W-1:0] cipher_y;

  // Shadow copies of the key registers
  logic [WORD_W-1:0] key_a = '0;
  logic [WORD_W-1:0] key_b = '0;

  word_pair_t pending_blocks[$];
  word_pair_t expected_cipher[$];
  int fail_count = 0;
  int blocks_taken = 0;

  speck_block_encrypt dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .block_x(block_x), .block_y(block_y),
    .out_valid(out_valid), .out_stall(out_stall), .cipher_x(cipher_x), .cipher_y(cipher_y)
  );

  always #4 clk = ~clk;

  // Speck128/128 encryption with the key schedule expanded alongside the rounds
  function automatic word_pair_t speck_encipher(input logic [WORD_W-1:0] px,
                                                input logic [WORD_W-1:0] py,
                                                input logic [WORD_W-1:0] ka,
                                                input logic [WORD_W-1:0] kb);
    logic [WORD_W-1:0] x, y, mix, rk;
    word_pair_t ct;
    x = px;
    y = py;
    mix = ka;
    rk = kb;
    for (int r = 0; r < ROUND_COUNT; r++) begin
      x = {x[7:0], x[WORD_W-1:8]} + y;
      x = x ^ rk;
      y = {y[WORD_W-4:0], y[WORD_W-1:WORD_W-3]} ^ x;
      mix = {mix[7:0], mix[WORD_W-1:8]} + rk;
      mix = mix ^ WORD_W'(r);
      rk = {rk[WORD_W-4:0], rk[WORD_W-1:WORD_W-3]} ^ mix;
    end
    ct.x = x;
    ct.y = y;
    return ct;
  endfunction

  // Random word biased toward zero, all ones and single set bits
  function automatic logic [WORD_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return '0;
      1: return ALL_ONES;
      2: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_fault(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  task automatic queue_block(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y);
    word_pair_t req;
    req.x = x;
    req.y = y;
    pending_blocks.insert(pending_blocks.size(), req);
  endtask

  // Block until every queued request is sent and every result is back, then idle a while
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_blocks.size() != 0 || in_valid || expected_cipher.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write either or both key registers; only called while the block is idle
  task automatic set_keys(input bit wr_a, input bit wr_b,
                          input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
    if (wr_a) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= REG_KEY_WORD_A;
      cfg_data <= a;
      key_a = a;
    end
    if (wr_b) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= REG_KEY_WORD_B;
      cfg_data <= b;
      key_b = b;
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Request driver: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;
  word_pair_t req_next;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        req_next = pending_blocks.pop_front();
        in_valid <= 1'b1;
        block_x <= req_next.x;
        block_y <= req_next.y;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: randomly changing patterns plus one long hold-off to back up the chain
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;
  int pattern_count = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && blocks_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left = mode_left - 1;
      end
      pattern_count = (pattern_count + 1) % 5;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 2);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (pattern_count < 2);
      endcase
    end
  end

  // Scoreboard: predict on each accepted request, compare each accepted result
  word_pair_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_cipher.insert(expected_cipher.size(),
                               speck_encipher(block_x, block_y, key_a, key_b));
        blocks_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_cipher.size() == 0) begin
          report_fault($sformatf("unexpected result x=%h y=%h", cipher_x, cipher_y));
        end else begin
          want = expected_cipher.pop_front();
          if (cipher_x !== want.x || cipher_y !== want.y)
            report_fault($sformatf("mismatch: expected x=%h y=%h, got x=%h y=%h",
                                   want.x, want.y, cipher_x, cipher_y));
        end
      end
    end
  end

  // Main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Field extremes under the reset keys
    queue_block('0, '0);
    queue_block(ALL_ONES, ALL_ONES);
    queue_block('0, ALL_ONES);
    queue_block(ALL_ONES, '0);
    queue_block(ALT_A, ALT_5);
    queue_block(WORD_W'(1), '0);
    queue_block('0, WORD_W'(1));
    queue_block(TOP_BIT, TOP_BIT);
    wait_drained();

    // All-ones key
    set_keys(1'b1, 1'b1, ALL_ONES, ALL_ONES);
    queue_block('0, '0);
    queue_block(ALL_ONES, ALL_ONES);
    queue_block(ALT_5, ALT_A);
    wait_drained();

    // Published key and plaintext
    set_keys(1'b1, 1'b1, VEC_KEY_A, VEC_KEY_B);
    queue_block(VEC_PT_X, VEC_PT_Y);
    queue_block(VEC_PT_Y, VEC_PT_X);
    wait_drained();

    // Mixed key extremes: key_word_a rewritten alone, then both registers rewritten
    set_keys(1'b1, 1'b0, '0, '0);
    queue_block(VEC_PT_X, VEC_PT_Y);
    queue_block(ALL_ONES, '0);
    wait_drained();
    set_keys(1'b1, 1'b1, ALL_ONES, '0);
    queue_block(VEC_PT_X, VEC_PT_Y);
    queue_block('0, ALL_ONES);
    wait_drained();

    // Random phases, each under its own key setting
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 3))
        0: set_keys(1'b1, 1'b0, pick_word(), key_b);
        1: set_keys(1'b0, 1'b1, key_a, pick_word());
        default: set_keys(1'b1, 1'b1, pick_word(), pick_word());
      endcase
      for (int i = 0; i < 75; i++) queue_block(pick_word(), pick_word());
      wait_drained();
    end

    if (expected_cipher.size() != 0)
      report_fault($sformatf("%0d results never arrived", expected_cipher.size()));
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### speck_block_encrypt.f
rtl/core/spk_pkg.sv
rtl/core/spk_round_cell.sv
rtl/core/speck_block_encrypt.sv
verif/testbench.sv
